[hdl/crmm_pkg.sv]
// Shared types, constants and helpers for the complex-by-real matrix multiplier.
// Used by crmm_store, crmm_mac and complex_real_matrix_multiply. No dependencies.
`default_nettype none

package crmm_pkg;

    // Field widths
    localparam int CFG_W       = 4;
    localparam int MODE_W      = 2;
    localparam int IDX_W       = 3;
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = 35;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 80;
    localparam int REG_IDX_W   = 2;

    // Default largest matrix dimension
    localparam int DEF_MAX_DIM = 8;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_B_COLS = 2'd3;

    // Input word kinds
    localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic clear;   // zero both accumulators
        logic mul_en;  // capture a new product
        logic mul_im;  // product uses the imaginary part of A
        logic acc_re;  // add held product into the real sum
        logic acc_im;  // add held product into the imaginary sum
    } mac_op_t;

    // Clamp a dimension register: zero acts as one, anything above lim acts as lim
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] r,
                                                   input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] v;
        v = r;
        if (r == '0)
            v = CFG_W'(1);
        else if (r > lim)
            v = lim;
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/crmm_store.sv]
// Entry stores for matrix A (complex, 32 bits) and matrix B (real, 16 bits).
// One write port and one registered read port each. Depends on crmm_pkg.
`default_nettype none

module crmm_store #(
    parameter int MAX_DIM = crmm_pkg::DEF_MAX_DIM
) (
    input  wire logic                                    clk,
    input  wire logic                                    a_we,
    input  wire logic                                    b_we,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      wr_addr,
    input  wire logic [crmm_pkg::PROD_W-1:0]             a_wdata,
    input  wire logic [crmm_pkg::DATA_W-1:0]             b_wdata,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      a_raddr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      b_raddr,
    output logic      [crmm_pkg::PROD_W-1:0]             a_rdata,
    output logic      [crmm_pkg::DATA_W-1:0]             b_rdata
);
    import crmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;

    logic [PROD_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];

    // A store: imaginary part high, real part low
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[wr_addr] <= a_wdata;
        end
        a_rdata <= a_mem[a_raddr];
    end

    // B store
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[wr_addr] <= b_wdata;
        end
        b_rdata <= b_mem[b_raddr];
    end

endmodule

`default_nettype wire

[hdl/crmm_mac.sv]
// Shared multiply-accumulate unit: one 16x16 signed multiplier, time-shared
// between real and imaginary parts, feeding two exact sums. Depends on crmm_pkg.
`default_nettype none

module crmm_mac (
    input  wire logic                               clk,
    input  wire crmm_pkg::mac_op_t                  op,
    input  wire logic [crmm_pkg::PROD_W-1:0]        a_entry,
    input  wire logic [crmm_pkg::DATA_W-1:0]        b_entry,
    output logic      [crmm_pkg::ACC_W-1:0]         acc_re,
    output logic      [crmm_pkg::ACC_W-1:0]         acc_im
);
    import crmm_pkg::*;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic        [ACC_W-1:0]  prod_ext;
    logic        [ACC_W-1:0]  acc_re_reg;
    logic        [ACC_W-1:0]  acc_im_reg;

    // Pick the part of A for this pass and multiply
    assign mul_a     = op.mul_im ? a_entry[PROD_W-1:DATA_W] : a_entry[DATA_W-1:0];
    assign prod_next = mul_a * $signed(b_entry);
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Hold the product, then fold it into the chosen sum
    always_ff @(posedge clk)
    begin
        if (op.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (op.clear)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            if (op.acc_re)
            begin
                acc_re_reg <= acc_re_reg + prod_ext;
            end
            if (op.acc_im)
            begin
                acc_im_reg <= acc_im_reg + prod_ext;
            end
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;

endmodule

`default_nettype wire

[hdl/complex_real_matrix_multiply.sv]
// Complex-by-real matrix multiplier, top level: sequencer, configuration and output register.
// Load words go straight into the stores while idle. A compute word passes through ST_START,
// then ST_READ, ST_MRE, ST_MIM, ST_ACC per term (one shared multiplier, two passes per term)
// and ST_EMIT hands each element over. On a dimension mismatch ST_START sends an error word.
// Reset (rst_n, asynchronous) sets the dimension registers to 1 and idles the sequencer;
// store contents are undefined until written. Depends on crmm_pkg, crmm_store, crmm_mac.
`default_nettype none

module complex_real_matrix_multiply #(
    parameter int MAX_DIM = crmm_pkg::DEF_MAX_DIM
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input words
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // s_tdata, from bit 0: row[3], col[3], a_re[16], a_im[16], b_value[16], zero[2]
    input  wire logic [crmm_pkg::IN_TDATA_W-1:0]       s_tdata,
    // s_tuser: mode[2]
    input  wire logic [crmm_pkg::MODE_W-1:0]           s_tuser,
    // Result words
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata, from bit 0: out_row[3], out_col[3], prod_re[35], prod_im[35], zero[4]
    output logic      [crmm_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                       m_tlast,
    // m_tuser: error[1]
    output logic                                       m_tuser,
    // Configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [crmm_pkg::REG_IDX_W-1:0]        cfg_index,
    input  wire logic [crmm_pkg::CFG_W-1:0]            cfg_data
);
    import crmm_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_MRE   = 3'd3;
    localparam logic [2:0] ST_MIM   = 3'd4;
    localparam logic [2:0] ST_ACC   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [IW-1:0]    k_reg, k_next;

    logic [CFG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DW-1:0]    dim_m, dim_n, dim_kb, dim_p;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_row_reg, out_row_next;
    logic [IDX_W-1:0] out_col_reg, out_col_next;
    logic [ACC_W-1:0] out_re_reg, out_re_next;
    logic [ACC_W-1:0] out_im_reg, out_im_next;
    logic             out_last_reg, out_last_next;
    logic             out_err_reg, out_err_next;
    logic             out_free;

    logic [IDX_W-1:0]  in_row, in_col;
    logic [DATA_W-1:0] in_a_re, in_a_im, in_b;
    logic              in_take, in_range;
    logic              a_we, b_we;
    logic [AW-1:0]     wr_addr, a_raddr, b_raddr;
    logic [PROD_W-1:0] a_rdata;
    logic [DATA_W-1:0] b_rdata;
    logic [ACC_W-1:0]  acc_re, acc_im;
    mac_op_t           mac_op;
    logic              k_last, j_last, i_last;

    // Unpack the input word
    assign in_row  = s_tdata[IDX_W-1:0];
    assign in_col  = s_tdata[2*IDX_W-1:IDX_W];
    assign in_a_re = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
    assign in_a_im = s_tdata[2*IDX_W+2*DATA_W-1:2*IDX_W+DATA_W];
    assign in_b    = s_tdata[2*IDX_W+3*DATA_W-1:2*IDX_W+2*DATA_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign in_range = (CFG_W'(in_row) < CFG_W'(MAX_DIM)) && (CFG_W'(in_col) < CFG_W'(MAX_DIM));

    // Store writes from load words
    assign a_we    = in_take && in_range && (s_tuser == MODE_LOAD_A);
    assign b_we    = in_take && in_range && (s_tuser == MODE_LOAD_B);
    assign wr_addr = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);

    // Store reads for term k of element (i, j)
    assign a_raddr = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign b_raddr = AW'(k_reg) * AW'(MAX_DIM) + AW'(j_reg);

    // Clamped dimensions
    assign dim_m  = DW'(clamp_dim(a_rows_reg, CFG_W'(MAX_DIM)));
    assign dim_n  = DW'(clamp_dim(a_cols_reg, CFG_W'(MAX_DIM)));
    assign dim_kb = DW'(clamp_dim(b_rows_reg, CFG_W'(MAX_DIM)));
    assign dim_p  = DW'(clamp_dim(b_cols_reg, CFG_W'(MAX_DIM)));

    assign k_last = (DW'(k_reg) == dim_n - DW'(1));
    assign j_last = (DW'(j_reg) == dim_p - DW'(1));
    assign i_last = (DW'(i_reg) == dim_m - DW'(1));

    assign out_free = !out_valid_reg || m_tready;

    crmm_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .clk     (clk),
        .a_we    (a_we),
        .b_we    (b_we),
        .wr_addr (wr_addr),
        .a_wdata ({in_a_im, in_a_re}),
        .b_wdata (in_b),
        .a_raddr (a_raddr),
        .b_raddr (b_raddr),
        .a_rdata (a_rdata),
        .b_rdata (b_rdata)
    );

    crmm_mac u_mac (
        .clk     (clk),
        .op      (mac_op),
        .a_entry (a_rdata),
        .b_entry (b_rdata),
        .acc_re  (acc_re),
        .acc_im  (acc_im)
    );

    // Sequencer and output register loading
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        mac_op         = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (s_tuser == MODE_COMPUTE))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (dim_n != dim_kb)
                begin
                    // Mismatch: one error word, then back to idle
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_row_next   = '0;
                        out_col_next   = '0;
                        out_re_next    = '0;
                        out_im_next    = '0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    i_next       = '0;
                    j_next       = '0;
                    k_next       = '0;
                    mac_op.clear = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MRE;
            end
            ST_MRE:
            begin
                mac_op.mul_en = 1'b1;
                state_next    = ST_MIM;
            end
            ST_MIM:
            begin
                mac_op.mul_en = 1'b1;
                mac_op.mul_im = 1'b1;
                mac_op.acc_re = 1'b1;
                state_next    = ST_ACC;
            end
            ST_ACC:
            begin
                mac_op.acc_im = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = ST_READ;
                end
            end
            ST_EMIT:
            begin
                // Hand the finished element to the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = IDX_W'(i_reg);
                    out_col_next   = IDX_W'(j_reg);
                    out_re_next    = acc_re;
                    out_im_next    = acc_im;
                    out_last_next  = i_last && j_last;
                    out_err_next   = 1'b0;
                    mac_op.clear   = 1'b1;
                    if (i_last && j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + IW'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IW'(1);
                        end
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_re_reg   <= out_re_next;
        out_im_reg   <= out_im_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // Dimension registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= CFG_W'(1);
            a_cols_reg <= CFG_W'(1);
            b_rows_reg <= CFG_W'(1);
            b_cols_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default:    a_rows_reg <= a_rows_reg;
            endcase
        end
    end

    // Pack the result word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - 2*IDX_W - 2*ACC_W){1'b0}},
                       out_im_reg, out_re_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

`default_nettype wire
